### design/dahs_pkg.sv
// dahs_pkg: shared types and constants of the d-ary heap sorter.
// Holds the controller state enum and the command/status structs.
// No dependencies.
`default_nettype none

package dahs_pkg;

	localparam int VALUE_W = 32;
	localparam int ARITY_W = 4;
	localparam logic [ARITY_W-1:0] ARITY_RESET = 4'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_BLD_RD,
		ST_BLD_V,
		ST_SIFT_INIT,
		ST_SIFT_RD,
		ST_SIFT_CMP,
		ST_SIFT_END,
		ST_SRT_RD_I,
		ST_SRT_RD_0,
		ST_SRT_WR,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	typedef enum logic [1:0] {
		RS_I,
		RS_ZERO,
		RS_CHILD,
		RS_K
	} rd_sel_t;

	typedef enum logic [1:0] {
		I_HOLD,
		I_BUILD,
		I_SORT,
		I_DEC
	} i_op_t;

	typedef enum logic [1:0] {
		SL_NONE,
		SL_BUILD,
		SL_SORT
	} sift_ld_t;

	typedef struct packed {
		logic     store_in;
		i_op_t    i_op;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     take_v;
		sift_ld_t sift_ld;
		logic     sift_init;
		logic     sift_cmp;
		logic     sift_step;
		logic     sift_fin;
		logic     wr_swap;
		logic     k_clr;
		logic     k_inc;
		logic     emit_ld;
		logic     run_clr;
	} cmd_t;

	typedef struct packed {
		logic n_zero;
		logic n_one;
		logic i_zero;
		logic i_one;
		logic child_ok;
		logic big_is_node;
		logic out_free;
		logic k_last;
	} sts_t;

endpackage

`default_nettype wire

### design/d_ary_heap_sorter.sv
// d_ary_heap_sorter: top level; joins dahs_ctrl and dahs_dp (uses dahs_pkg).
// Load: one input transfer per cycle until the item marked last.
// Sort: heap build from node n/2 down, then n-1 extractions; each sift level
// reads the node's children one at a time on the single memory read port.
// Emit: each result is read, then loaded; a read waits until the output is free.
// Reset clears control state and sets arity to 2; the element memory is not cleared.
`default_nettype none

module d_ary_heap_sorter #(
	parameter int CAPACITY  = 64,
	parameter int MAX_ARITY = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 arity_we,
	input  wire logic [dahs_pkg::ARITY_W-1:0]         arity_wdata,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [dahs_pkg::VALUE_W-1:0]  value,
	input  wire logic                                 last,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [dahs_pkg::VALUE_W-1:0]       sorted_value,
	output logic                                      final_res,
	output logic                                      dropped
);

	dahs_pkg::cmd_t cmd;
	dahs_pkg::sts_t sts;

	dahs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	dahs_dp #(
		.CAPACITY  (CAPACITY),
		.MAX_ARITY (MAX_ARITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.arity_we     (arity_we),
		.arity_wdata  (arity_wdata),
		.value        (value),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.sorted_value (sorted_value),
		.final_res    (final_res),
		.dropped      (dropped)
	);

`ifndef SYNTH
	a_drop_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> final_res)
		else $error("dropped flag on a non-final result");

	a_rise_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result loaded while input was open");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_ld |-> !out_valid)
		else $error("output register overwritten before transfer");

	a_child_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en && cmd.rd_sel == dahs_pkg::RS_CHILD |-> sts.child_ok)
		else $error("child read outside heap");
`endif

endmodule

`default_nettype wire

### design/dahs_dp.sv
// dahs_dp: datapath of the d-ary heap sorter: element memory, sift registers,
// index counters, arity register and output register.
// Depends on dahs_pkg; driven by dahs_ctrl through cmd_t.
`default_nettype none

module dahs_dp #(
	parameter int CAPACITY  = 64,
	parameter int MAX_ARITY = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 arity_we,
	input  wire logic [dahs_pkg::ARITY_W-1:0]         arity_wdata,
	input  wire logic signed [dahs_pkg::VALUE_W-1:0]  value,
	input  wire logic                                 out_stall,
	input  wire dahs_pkg::cmd_t                       cmd,
	output dahs_pkg::sts_t                            sts,
	output logic                                      out_valid,
	output logic signed [dahs_pkg::VALUE_W-1:0]       sorted_value,
	output logic                                      final_res,
	output logic                                      dropped
);

	localparam int AW = $clog2(CAPACITY);
	localparam int NW = $clog2(CAPACITY + 1);
	localparam int DW = $clog2(MAX_ARITY + 1);
	localparam int CW = $clog2(MAX_ARITY * CAPACITY + MAX_ARITY + 2);

	logic signed [dahs_pkg::VALUE_W-1:0] mem [CAPACITY];

	logic [dahs_pkg::ARITY_W-1:0]        arity_q;
	logic [NW-1:0]                       count_q;
	logic                                ovf_q;
	logic                                out_valid_q;
	logic [AW-1:0]                       i_q;
	logic [AW-1:0]                       node_q;
	logic [NW-1:0]                       size_q;
	logic [CW-1:0]                       c_q;
	logic [DW-1:0]                       j_q;
	logic [AW-1:0]                       big_q;
	logic signed [dahs_pkg::VALUE_W-1:0] v_q;
	logic signed [dahs_pkg::VALUE_W-1:0] bigv_q;
	logic [AW-1:0]                       k_q;
	logic signed [dahs_pkg::VALUE_W-1:0] rdata_q;
	logic signed [dahs_pkg::VALUE_W-1:0] out_value_q;
	logic                                out_final_q;
	logic                                out_drop_q;

	logic [dahs_pkg::ARITY_W:0]          a_ext;
	logic [DW-1:0]                       eff;
	logic                                full;
	logic                                we;
	logic [AW-1:0]                       wa;
	logic signed [dahs_pkg::VALUE_W-1:0] wd;
	logic [AW-1:0]                       ra;
	logic                                k_last;

	always_comb begin
		a_ext = {1'b0, arity_q};
		if (a_ext < (dahs_pkg::ARITY_W+1)'(2)) begin
			eff = DW'(2);
		end else if (a_ext > (dahs_pkg::ARITY_W+1)'(MAX_ARITY)) begin
			eff = DW'(MAX_ARITY);
		end else begin
			eff = DW'(a_ext);
		end
	end

	assign full   = (count_q == NW'(CAPACITY));
	assign k_last = ((NW'(k_q) + NW'(1)) == count_q);

	always_comb begin
		we = 1'b0;
		wa = count_q[AW-1:0];
		wd = value;
		priority if (cmd.store_in) begin
			we = !full;
		end else if (cmd.wr_swap) begin
			we = 1'b1;
			wa = i_q;
			wd = rdata_q;
		end else if (cmd.sift_step) begin
			we = 1'b1;
			wa = node_q;
			wd = bigv_q;
		end else if (cmd.sift_fin) begin
			we = 1'b1;
			wa = node_q;
			wd = v_q;
		end else begin
			we = 1'b0;
		end
	end

	always_comb begin
		unique case (cmd.rd_sel)
			dahs_pkg::RS_I:     ra = i_q;
			dahs_pkg::RS_ZERO:  ra = '0;
			dahs_pkg::RS_CHILD: ra = c_q[AW-1:0];
			dahs_pkg::RS_K:     ra = k_q;
			default:            ra = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arity_q     <= dahs_pkg::ARITY_RESET;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (arity_we) begin
				arity_q <= arity_wdata;
			end
			if (cmd.run_clr) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (cmd.store_in) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + NW'(1);
				end
			end
			if (cmd.emit_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.i_op)
			dahs_pkg::I_HOLD:  i_q <= i_q;
			dahs_pkg::I_BUILD: i_q <= AW'(count_q >> 1);
			dahs_pkg::I_SORT:  i_q <= AW'(count_q - NW'(1));
			dahs_pkg::I_DEC:   i_q <= i_q - AW'(1);
			default:           i_q <= i_q;
		endcase
		if (cmd.take_v) begin
			v_q <= rdata_q;
		end
		unique case (cmd.sift_ld)
			dahs_pkg::SL_BUILD: begin
				node_q <= i_q;
				size_q <= count_q;
			end
			dahs_pkg::SL_SORT: begin
				node_q <= '0;
				size_q <= NW'(i_q);
			end
			default: begin
				if (cmd.sift_step) begin
					node_q <= big_q;
				end
			end
		endcase
		if (cmd.sift_init) begin
			c_q    <= CW'(eff) * CW'(node_q) + CW'(1);
			j_q    <= '0;
			big_q  <= node_q;
			bigv_q <= v_q;
		end else if (cmd.sift_cmp) begin
			if (rdata_q > bigv_q) begin
				big_q  <= c_q[AW-1:0];
				bigv_q <= rdata_q;
			end
			c_q <= c_q + CW'(1);
			j_q <= j_q + DW'(1);
		end
		if (cmd.k_clr) begin
			k_q <= '0;
		end else if (cmd.k_inc) begin
			k_q <= k_q + AW'(1);
		end
		if (cmd.emit_ld) begin
			out_value_q <= rdata_q;
			out_final_q <= k_last;
			out_drop_q  <= k_last && ovf_q;
		end
	end

	always_comb begin
		sts.n_zero      = (count_q == '0);
		sts.n_one       = (count_q == NW'(1));
		sts.i_zero      = (i_q == '0);
		sts.i_one       = (i_q == AW'(1));
		sts.child_ok    = (c_q < CW'(size_q)) && (j_q < eff);
		sts.big_is_node = (big_q == node_q);
		sts.out_free    = !out_valid_q || !out_stall;
		sts.k_last      = k_last;
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = out_value_q;
	assign final_res    = out_final_q;
	assign dropped      = out_drop_q;

endmodule

`default_nettype wire

### design/dahs_ctrl.sv
// dahs_ctrl: controller of the d-ary heap sorter: load, heap build, sort and
// emit sequencing. Depends on dahs_pkg; issues cmd_t, reads sts_t.
`default_nettype none

module dahs_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            last,
	input  wire dahs_pkg::sts_t  sts,
	output logic                 in_stall,
	output dahs_pkg::cmd_t       cmd
);

	dahs_pkg::state_t state_q;
	dahs_pkg::state_t state_nx;
	logic             sort_q;
	logic             sort_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dahs_pkg::ST_IDLE;
			sort_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			sort_q  <= sort_nx;
		end
	end

	always_comb begin
		state_nx      = state_q;
		sort_nx       = sort_q;
		in_stall      = 1'b1;
		cmd.store_in  = 1'b0;
		cmd.i_op      = dahs_pkg::I_HOLD;
		cmd.rd_en     = 1'b0;
		cmd.rd_sel    = dahs_pkg::RS_I;
		cmd.take_v    = 1'b0;
		cmd.sift_ld   = dahs_pkg::SL_NONE;
		cmd.sift_init = 1'b0;
		cmd.sift_cmp  = 1'b0;
		cmd.sift_step = 1'b0;
		cmd.sift_fin  = 1'b0;
		cmd.wr_swap   = 1'b0;
		cmd.k_clr     = 1'b0;
		cmd.k_inc     = 1'b0;
		cmd.emit_ld   = 1'b0;
		cmd.run_clr   = 1'b0;
		unique case (state_q)
			dahs_pkg::ST_IDLE: begin
				in_stall     = 1'b0;
				cmd.store_in = in_valid;
				if (in_valid && last) begin
					state_nx = dahs_pkg::ST_START;
				end
			end
			dahs_pkg::ST_START: begin
				sort_nx = 1'b0;
				priority if (sts.n_zero) begin
					cmd.run_clr = 1'b1;
					state_nx    = dahs_pkg::ST_IDLE;
				end else if (sts.n_one) begin
					cmd.k_clr = 1'b1;
					state_nx  = dahs_pkg::ST_EMIT_RD;
				end else begin
					cmd.i_op = dahs_pkg::I_BUILD;
					state_nx = dahs_pkg::ST_BLD_RD;
				end
			end
			dahs_pkg::ST_BLD_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = dahs_pkg::RS_I;
				state_nx   = dahs_pkg::ST_BLD_V;
			end
			dahs_pkg::ST_BLD_V: begin
				cmd.take_v  = 1'b1;
				cmd.sift_ld = dahs_pkg::SL_BUILD;
				state_nx    = dahs_pkg::ST_SIFT_INIT;
			end
			dahs_pkg::ST_SIFT_INIT: begin
				cmd.sift_init = 1'b1;
				state_nx      = dahs_pkg::ST_SIFT_RD;
			end
			dahs_pkg::ST_SIFT_RD: begin
				if (sts.child_ok) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = dahs_pkg::RS_CHILD;
					state_nx   = dahs_pkg::ST_SIFT_CMP;
				end else begin
					state_nx = dahs_pkg::ST_SIFT_END;
				end
			end
			dahs_pkg::ST_SIFT_CMP: begin
				cmd.sift_cmp = 1'b1;
				state_nx     = dahs_pkg::ST_SIFT_RD;
			end
			dahs_pkg::ST_SIFT_END: begin
				if (!sts.big_is_node) begin
					cmd.sift_step = 1'b1;
					state_nx      = dahs_pkg::ST_SIFT_INIT;
				end else begin
					cmd.sift_fin = 1'b1;
					priority if (!sort_q && sts.i_zero) begin
						cmd.i_op = dahs_pkg::I_SORT;
						sort_nx  = 1'b1;
						state_nx = dahs_pkg::ST_SRT_RD_I;
					end else if (!sort_q) begin
						cmd.i_op = dahs_pkg::I_DEC;
						state_nx = dahs_pkg::ST_BLD_RD;
					end else if (sts.i_one) begin
						cmd.k_clr = 1'b1;
						state_nx  = dahs_pkg::ST_EMIT_RD;
					end else begin
						cmd.i_op = dahs_pkg::I_DEC;
						state_nx = dahs_pkg::ST_SRT_RD_I;
					end
				end
			end
			dahs_pkg::ST_SRT_RD_I: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = dahs_pkg::RS_I;
				state_nx   = dahs_pkg::ST_SRT_RD_0;
			end
			dahs_pkg::ST_SRT_RD_0: begin
				cmd.take_v = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = dahs_pkg::RS_ZERO;
				state_nx   = dahs_pkg::ST_SRT_WR;
			end
			dahs_pkg::ST_SRT_WR: begin
				cmd.wr_swap = 1'b1;
				cmd.sift_ld = dahs_pkg::SL_SORT;
				state_nx    = dahs_pkg::ST_SIFT_INIT;
			end
			dahs_pkg::ST_EMIT_RD: begin
				if (sts.out_free) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = dahs_pkg::RS_K;
					state_nx   = dahs_pkg::ST_EMIT_LD;
				end
			end
			dahs_pkg::ST_EMIT_LD: begin
				cmd.emit_ld = 1'b1;
				if (sts.k_last) begin
					cmd.run_clr = 1'b1;
					state_nx    = dahs_pkg::ST_IDLE;
				end else begin
					cmd.k_inc = 1'b1;
					state_nx  = dahs_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_nx = dahs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire
